// ===== rtl/pinhole_project_and_backproject_core_macros.svh =====
// Assertion macros for the pinhole projection core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PINHOLE_PROJECT_AND_BACKPROJECT_CORE_MACROS_SVH
`define PINHOLE_PROJECT_AND_BACKPROJECT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PH_ASSERT(lbl, prop, msg)
`define PH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/pinhole_pkg.sv =====
// Shared types and constants of the pinhole projection core.
// No dependencies.
package pinhole_pkg;
    localparam int COEF_W        = 32;
    localparam int ADJ_W         = 2 * COEF_W + 1;
    localparam int ACC_W         = 3 * COEF_W + 3;
    localparam int OUT_FRAC_BITS = 24;
    localparam int NUM_REGS      = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int NUM_LANES     = 6;
    localparam int SETTLE_CYC    = 4;
    localparam int SETTLE_W      = 3;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'd4096, 64'd0, 64'h0000_1000_0000_0000, 64'd0, 64'd0, 64'd4096
    };

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic valid;
        logic mode;
        logic zero;
    } ctl_t;
endpackage

// ===== rtl/pinhole_if.sv =====
// Item channels of the pinhole projection core: input point and result.
// No dependencies.
interface pinhole_point_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
    modport sink (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface pinhole_result_if #(parameter int OUT_WIDTH = 48);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] pixel_u;
    logic signed [OUT_WIDTH-1:0] pixel_v;
    logic signed [OUT_WIDTH-1:0] center_x;
    logic signed [OUT_WIDTH-1:0] center_y;
    logic signed [OUT_WIDTH-1:0] center_z;
    logic signed [OUT_WIDTH-1:0] dir_x;
    logic signed [OUT_WIDTH-1:0] dir_y;
    logic signed [OUT_WIDTH-1:0] dir_z;
    logic [1:0]                  status;
    modport source (output valid, pixel_u, pixel_v, center_x, center_y, center_z,
                    dir_x, dir_y, dir_z, status, input ready);
    modport sink (input valid, pixel_u, pixel_v, center_x, center_y, center_z,
                  dir_x, dir_y, dir_z, status, output ready);
endinterface

// ===== rtl/pinhole_adj.sv =====
// Adjugate, determinant and adj*p4 of the camera matrix, four register stages.
// Depends on pinhole_pkg.
module pinhole_adj (
    input  logic                                      clk,
    input  logic signed [pinhole_pkg::COEF_W-1:0]     coef [3][4],
    output logic signed [pinhole_pkg::ADJ_W-1:0]      adj  [3][3],
    output logic signed [pinhole_pkg::ACC_W-1:0]      det,
    output logic signed [pinhole_pkg::ACC_W-1:0]      cvec [3]
);
    localparam int CW = pinhole_pkg::COEF_W;
    localparam int AW = pinhole_pkg::ACC_W;
    localparam int PW = CW + CW + 1;

    logic signed [2*CW-1:0] pa_reg [3][3];
    logic signed [2*CW-1:0] pb_reg [3][3];
    logic signed [pinhole_pkg::ADJ_W-1:0] adj_reg [3][3];
    logic signed [PW-1:0] dl_reg [3];
    logic signed [PW-1:0] dh_reg [3];
    logic signed [PW-1:0] cl_reg [3][3];
    logic signed [PW-1:0] ch_reg [3][3];
    logic signed [AW-1:0] det_reg;
    logic signed [AW-1:0] c_reg [3];
    logic signed [AW-1:0] det_next;
    logic signed [AW-1:0] c_next [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pa_reg[i][j] <= coef[(j+1)%3][(i+1)%3] * coef[(j+2)%3][(i+2)%3];
                pb_reg[i][j] <= coef[(j+1)%3][(i+2)%3] * coef[(j+2)%3][(i+1)%3];
                adj_reg[i][j] <= pinhole_pkg::ADJ_W'(pa_reg[i][j])
                               - pinhole_pkg::ADJ_W'(pb_reg[i][j]);
                cl_reg[i][j] <= $signed({1'b0, adj_reg[i][j][CW-1:0]}) * coef[j][3];
                ch_reg[i][j] <= $signed(adj_reg[i][j][pinhole_pkg::ADJ_W-1:CW]) * coef[j][3];
            end
            dl_reg[i] <= $signed({1'b0, adj_reg[i][0][CW-1:0]}) * coef[0][i];
            dh_reg[i] <= $signed(adj_reg[i][0][pinhole_pkg::ADJ_W-1:CW]) * coef[0][i];
        end
        det_reg <= det_next;
        for (int i = 0; i < 3; i++)
        begin
            c_reg[i] <= c_next[i];
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (AW'(dh_reg[j]) <<< CW) + AW'(dl_reg[j]);
        end
        for (int i = 0; i < 3; i++)
        begin
            c_next[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                c_next[i] = c_next[i] + (AW'(ch_reg[i][j]) <<< CW) + AW'(cl_reg[i][j]);
            end
        end
    end

    assign adj  = adj_reg;
    assign det  = det_reg;
    assign cvec = c_reg;
endmodule

// ===== rtl/pinhole_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage, overflow precheck.
// No dependencies; every register advances only while en is high.
module pinhole_div #(
    parameter int NUM_W = 123,
    parameter int DEN_W = 99,
    parameter int Q_W   = 48
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg_in,
    output logic [Q_W-1:0]   quo,
    output logic             sat,
    output logic             neg_out
);
    localparam int SH_W = DEN_W + Q_W;
    localparam int R_W  = (NUM_W > SH_W) ? NUM_W : SH_W;

    logic [R_W-1:0]   r_reg   [Q_W+1];
    logic [DEN_W-1:0] d_reg   [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic             sat_reg [Q_W+1];
    logic             neg_reg [Q_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= R_W'(num);
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= R_W'(num) >= (R_W'(den) << Q_W);
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - k;
        logic [R_W-1:0] t;
        logic           ge;
        assign t  = R_W'(d_reg[k-1]) << B;
        assign ge = r_reg[k-1] >= t;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= ge ? (r_reg[k-1] - t) : r_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (Q_W'(ge) << B);
                sat_reg[k] <= sat_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo     = q_reg[Q_W];
    assign sat     = sat_reg[Q_W];
    assign neg_out = neg_reg[Q_W];
endmodule

// ===== rtl/pinhole_project_and_backproject_core.sv =====
// Channel   | Dir | Carries
// point     | in  | mode, coord_x, coord_y, coord_z
// result    | out | pixel_u/v, center_x/y/z, dir_x/y/z, status
// cfg_*     | in  | register writes, index 0..5
// One item per cycle unless settle or a result stall holds point.ready low.
// Four front stages, divider lanes of OUT_WIDTH + 1 stages, output register.
// After reset and after each register write, point.ready stays low while the
// settle counter runs down and the adjugate and determinant are recomputed.
// A stall at the result freezes the whole pipeline; valid bits travel with data.
`include "pinhole_project_and_backproject_core_macros.svh"
module pinhole_project_and_backproject_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int COORD_FRAC_BITS = 12,
    parameter int OUT_WIDTH       = 48
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    pinhole_point_if.sink                          point,
    pinhole_result_if.source                       result,
    input  logic                                   cfg_we,
    input  logic [pinhole_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pinhole_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int CF    = pinhole_pkg::COEF_W;
    localparam int AW    = pinhole_pkg::ACC_W;
    localparam int ADW   = pinhole_pkg::ADJ_W;
    localparam int NL    = pinhole_pkg::NUM_LANES;
    localparam int NUM_W = AW + pinhole_pkg::OUT_FRAC_BITS;
    localparam int PM_W  = CF + COORD_WIDTH;
    localparam int PA_W  = CF + 1 + COORD_WIDTH;
    localparam int OW    = OUT_WIDTH;

    // configuration
    logic [pinhole_pkg::CFG_DATA_W-1:0] cfg_reg [pinhole_pkg::NUM_REGS];
    logic [pinhole_pkg::SETTLE_W-1:0]   settle_reg, settle_next;
    logic signed [CF-1:0]               coef [3][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pinhole_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= pinhole_pkg::CFG_RESET[i];
            end
            settle_reg <= pinhole_pkg::SETTLE_W'(pinhole_pkg::SETTLE_CYC);
        end
        else
        begin
            if (cfg_we && cfg_index < pinhole_pkg::CFG_IDX_W'(pinhole_pkg::NUM_REGS))
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            settle_reg <= settle_next;
        end
    end

    always_comb
    begin
        if (cfg_we)
        begin
            settle_next = pinhole_pkg::SETTLE_W'(pinhole_pkg::SETTLE_CYC);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        else
        begin
            settle_next = '0;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 4; j++)
        begin : g_col
            assign coef[i][j] = cfg_reg[i*2 + j/2][(j%2)*CF +: CF];
        end
    end

    logic signed [ADW-1:0] adj [3][3];
    logic signed [AW-1:0]  det;
    logic signed [AW-1:0]  cvec [3];

    pinhole_adj u_adj (
        .clk  (clk),
        .coef (coef),
        .adj  (adj),
        .det  (det),
        .cvec (cvec)
    );

    // pipeline control
    logic en;
    logic res_valid_reg;
    logic signed [AW-1:0] den3_reg;
    logic                 den3_zero;
    pinhole_pkg::ctl_t c1_reg, c2_reg, c3_reg, c4_reg;
    pinhole_pkg::ctl_t cd_reg [OW+1];

    assign en          = !res_valid_reg || result.ready;
    assign point.ready = en && (settle_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            for (int k = 0; k <= OW; k++)
            begin
                cd_reg[k] <= '0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_reg <= '{valid: point.valid && point.ready, mode: point.mode, zero: 1'b0};
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= '{valid: c3_reg.valid, mode: c3_reg.mode, zero: den3_zero};
            cd_reg[0] <= c4_reg;
            for (int k = 1; k <= OW; k++)
            begin
                cd_reg[k] <= cd_reg[k-1];
            end
            res_valid_reg <= cd_reg[OW].valid;
        end
    end

    // stage 1: input register
    logic signed [COORD_WIDTH-1:0] xyz1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xyz1_reg[0] <= point.coord_x;
            xyz1_reg[1] <= point.coord_y;
            xyz1_reg[2] <= point.coord_z;
        end
    end

    // stage 2: products
    logic signed [PM_W-1:0] pm_reg [3][3];
    logic signed [PA_W-1:0] al_reg [3][2];
    logic signed [PA_W-1:0] ah_reg [3][2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pm_reg[i][j] <= coef[i][j] * xyz1_reg[j];
                end
                for (int j = 0; j < 2; j++)
                begin
                    al_reg[i][j] <= $signed({1'b0, adj[i][j][CF-1:0]}) * xyz1_reg[j];
                    ah_reg[i][j] <= $signed(adj[i][j][ADW-1:CF]) * xyz1_reg[j];
                end
            end
        end
    end

    // stage 3: sums, lane numerators and shared denominator
    logic signed [AW-1:0] acc [3];
    logic signed [AW-1:0] dv [3];
    logic signed [AW-1:0] num3_reg [NL];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = AW'(pm_reg[i][0]) + AW'(pm_reg[i][1]) + AW'(pm_reg[i][2])
                   + (AW'(coef[i][3]) <<< COORD_FRAC_BITS);
            dv[i] = (AW'(ah_reg[i][0]) <<< CF) + AW'(al_reg[i][0])
                  + (AW'(ah_reg[i][1]) <<< CF) + AW'(al_reg[i][1])
                  + (AW'(adj[i][2]) <<< COORD_FRAC_BITS);
        end
    end

    assign den3_zero = (den3_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c2_reg.mode)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num3_reg[i]     <= -cvec[i];
                    num3_reg[3 + i] <= dv[i];
                end
                den3_reg <= det;
            end
            else
            begin
                num3_reg[0] <= acc[0];
                num3_reg[1] <= acc[1];
                for (int k = 2; k < NL; k++)
                begin
                    num3_reg[k] <= '0;
                end
                den3_reg <= acc[2];
            end
        end
    end

    // stage 4: magnitudes and signs
    logic [AW-1:0] na4_reg [NL];
    logic [AW-1:0] da4_reg;
    logic          neg4_reg [NL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NL; k++)
            begin
                na4_reg[k]  <= num3_reg[k][AW-1] ? AW'(-num3_reg[k]) : AW'(num3_reg[k]);
                neg4_reg[k] <= num3_reg[k][AW-1] ^ den3_reg[AW-1];
            end
            da4_reg <= den3_reg[AW-1] ? AW'(-den3_reg) : AW'(den3_reg);
        end
    end

    // divider lanes
    logic [OW-1:0] quo [NL];
    logic          qsat [NL];
    logic          qneg [NL];

    for (genvar k = 0; k < NL; k++)
    begin : g_lane
        pinhole_div #(
            .NUM_W (NUM_W),
            .DEN_W (AW),
            .Q_W   (OW)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num     ({na4_reg[k], pinhole_pkg::OUT_FRAC_BITS'(0)}),
            .den     (da4_reg),
            .neg_in  (neg4_reg[k]),
            .quo     (quo[k]),
            .sat     (qsat[k]),
            .neg_out (qneg[k])
        );
    end

    // output stage: saturate, sign, select fields, clear on zero, set status
    logic [OW-1:0] lval [NL];
    logic          lsat [NL];
    logic [OW-1:0] limit [NL];
    logic          any_sat;
    logic [OW-1:0] f_next [8];
    logic [1:0]    st_next;
    logic [OW-1:0] f_reg [8];
    logic [1:0]    st_reg;

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            limit[k] = qneg[k] ? (OW'(1) << (OW - 1)) : ((OW'(1) << (OW - 1)) - 1'b1);
            lsat[k]  = qsat[k] || (quo[k] > limit[k]);
            lval[k]  = lsat[k] ? limit[k] : quo[k];
            lval[k]  = qneg[k] ? -lval[k] : lval[k];
        end
        for (int f = 0; f < 8; f++)
        begin
            f_next[f] = '0;
        end
        if (cd_reg[OW].mode)
        begin
            for (int k = 0; k < NL; k++)
            begin
                f_next[2 + k] = lval[k];
            end
            any_sat = lsat[0] || lsat[1] || lsat[2] || lsat[3] || lsat[4] || lsat[5];
        end
        else
        begin
            f_next[0] = lval[0];
            f_next[1] = lval[1];
            any_sat   = lsat[0] || lsat[1];
        end
        if (cd_reg[OW].zero)
        begin
            for (int f = 0; f < 8; f++)
            begin
                f_next[f] = '0;
            end
            st_next = pinhole_pkg::ST_ZERO;
        end
        else if (any_sat)
        begin
            st_next = pinhole_pkg::ST_SAT;
        end
        else
        begin
            st_next = pinhole_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg  <= f_next;
            st_reg <= st_next;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.pixel_u  = f_reg[0];
    assign result.pixel_v  = f_reg[1];
    assign result.center_x = f_reg[2];
    assign result.center_y = f_reg[3];
    assign result.center_z = f_reg[4];
    assign result.dir_x    = f_reg[5];
    assign result.dir_y    = f_reg[6];
    assign result.dir_z    = f_reg[7];
    assign result.status   = st_reg;

    `PH_ASSERT_NEXT(a_cfg_blocks, cfg_we, !point.ready, "item accepted right after cfg write")
    `PH_ASSERT(a_settle_blocks, (settle_reg == '0) || !point.ready, "ready during settle")
    `PH_ASSERT(a_zero_clears, !(result.valid && result.status == pinhole_pkg::ST_ZERO) || (result.pixel_u == '0 && result.center_x == '0 && result.dir_z == '0), "zero status with data")
    `PH_ASSERT(a_stall_holds, !(en && !point.ready && point.valid && settle_reg == '0), "ready dropped without cause")
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for pinhole_project_and_backproject_core.
// Depends on rtl/pinhole_pkg.sv, rtl/pinhole_if.sv and the core itself.
// A 160-bit-exact predictor of projection and back-projection checks every result item.
`timescale 1ns / 100ps

module testbench;
    localparam int CW       = 32;
    localparam int OW       = 48;
    localparam int LATENCY  = OW + 6;
    localparam int MAX_CYC  = 400000;
    localparam int IDX_W    = pinhole_pkg::CFG_IDX_W;
    localparam int DATA_W   = pinhole_pkg::CFG_DATA_W;

    localparam logic MODE_PROJECT     = 1'b0;
    localparam logic MODE_BACKPROJECT = 1'b1;

    localparam logic [IDX_W-1:0] REG_ROW0_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_A = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_B = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_A = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_B = 3'd5;
    localparam logic [IDX_W-1:0] REG_BAD_6  = 3'd6;
    localparam logic [IDX_W-1:0] REG_BAD_7  = 3'd7;

    localparam logic [31:0] Q_ONE = 32'h0000_1000;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic signed [OW-1:0] field[8];
        logic [1:0]           status;
    } ray_pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;

    pinhole_point_if  #(.COORD_WIDTH(CW)) point_ch ();
    pinhole_result_if #(.OUT_WIDTH(OW))   result_ch ();

    pinhole_project_and_backproject_core #(
        .COORD_WIDTH(CW),
        .COORD_FRAC_BITS(12),
        .OUT_WIDTH(OW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .point(point_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [DATA_W-1:0] camera_regs[pinhole_pkg::NUM_REGS];
    ray_pixel_t            pending_results[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    logic hold_off;
    int  error_count;
    int  items_sent;
    int  results_seen;
    int  sat_seen;
    int  zero_seen;
    int  cycle_count;
    string field_names[8] = '{"pixel_u", "pixel_v", "center_x", "center_y", "center_z",
                              "dir_x", "dir_y", "dir_z"};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("pinhole_project_and_backproject_core regression: fail");
            $finish;
        end
    end

    function automatic wide_t coef(int row, int col);
        logic [63:0] r;
        logic signed [31:0] h;
        r = camera_regs[row * 2 + col / 2];
        h = (col % 2) ? r[63:32] : r[31:0];
        return wide_t'(h);
    endfunction

    // truncating num * 2^24 / den, saturated to OW bits
    function automatic logic signed [OW-1:0] divide_q24(wide_t num, wide_t den, inout bit sat);
        logic neg;
        logic [159:0] n, d, q, limit, mag;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        n = n << pinhole_pkg::OUT_FRAC_BITS;
        q = n / d;
        limit = neg ? (160'd1 << (OW - 1)) : ((160'd1 << (OW - 1)) - 1);
        mag = q;
        if (q > limit)
        begin
            sat = 1'b1;
            mag = limit;
        end
        if (neg)
            mag = -mag;
        return mag[OW-1:0];
    endfunction

    function automatic ray_pixel_t predict_camera(logic mode, logic signed [CW-1:0] x,
                                                  logic signed [CW-1:0] y,
                                                  logic signed [CW-1:0] z);
        ray_pixel_t res;
        wide_t pt[4];
        wide_t acc[3];
        wide_t m[3][3];
        wide_t adj[3][3];
        wide_t p4[3];
        wide_t det, c, d;
        bit sat;
        sat = 1'b0;
        foreach (res.field[k])
            res.field[k] = '0;
        res.status = pinhole_pkg::ST_OK;
        pt[0] = wide_t'(x);
        pt[1] = wide_t'(y);
        pt[2] = (mode == MODE_PROJECT) ? wide_t'(z) : wide_t'(signed'(Q_ONE));
        pt[3] = wide_t'(signed'(Q_ONE));
        if (mode == MODE_PROJECT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc[i] = 0;
                for (int j = 0; j < 4; j++)
                    acc[i] = acc[i] + coef(i, j) * pt[j];
            end
            if (acc[2] == 0)
            begin
                res.status = pinhole_pkg::ST_ZERO;
                return res;
            end
            res.field[0] = divide_q24(acc[0], acc[2], sat);
            res.field[1] = divide_q24(acc[1], acc[2], sat);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    m[i][j] = coef(i, j);
                p4[i] = coef(i, 3);
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                              - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
            det = 0;
            for (int j = 0; j < 3; j++)
                det = det + m[0][j] * adj[j][0];
            if (det == 0)
            begin
                res.status = pinhole_pkg::ST_ZERO;
                return res;
            end
            for (int i = 0; i < 3; i++)
            begin
                c = 0;
                d = 0;
                for (int j = 0; j < 3; j++)
                begin
                    c = c + adj[i][j] * p4[j];
                    d = d + adj[i][j] * pt[j];
                end
                res.field[2 + i] = divide_q24(-c, det, sat);
                res.field[5 + i] = divide_q24(d, det, sat);
            end
        end
        res.status = sat ? pinhole_pkg::ST_SAT : pinhole_pkg::ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic signed [OW-1:0] got,
                                   logic signed [OW-1:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        ray_pixel_t want;
        logic signed [OW-1:0] got[8];
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            got = '{result_ch.pixel_u, result_ch.pixel_v, result_ch.center_x,
                    result_ch.center_y, result_ch.center_z, result_ch.dir_x,
                    result_ch.dir_y, result_ch.dir_z};
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result item with nothing expected", $time);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status == pinhole_pkg::ST_SAT)
                    sat_seen++;
                if (want.status == pinhole_pkg::ST_ZERO)
                    zero_seen++;
                for (int k = 0; k < 8; k++)
                    if (got[k] !== want.field[k])
                        report_mismatch(field_names[k], got[k], want.field[k]);
                if (result_ch.status !== want.status)
                    report_mismatch("status", OW'(result_ch.status), OW'(want.status));
            end
        end
    end

    task automatic send_point(logic mode, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [CW-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.mode    <= mode;
        point_ch.coord_x <= x;
        point_ch.coord_y <= y;
        point_ch.coord_z <= z;
        do
            @(posedge clk);
        while (!point_ch.ready);
        pending_results.push_back(predict_camera(mode, x, y, z));
        items_sent++;
    endtask

    task automatic drain;
        point_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < pinhole_pkg::NUM_REGS)
            camera_regs[idx] = val;
    endtask

    function automatic logic [63:0] pack2(logic [31:0] lo, logic [31:0] hi);
        return {hi, lo};
    endfunction

    task automatic load_camera(logic [31:0] c[12]);
        write_reg(REG_ROW0_A, pack2(c[0], c[1]));
        write_reg(REG_ROW0_B, pack2(c[2], c[3]));
        write_reg(REG_ROW1_A, pack2(c[4], c[5]));
        write_reg(REG_ROW1_B, pack2(c[6], c[7]));
        write_reg(REG_ROW2_A, pack2(c[8], c[9]));
        write_reg(REG_ROW2_B, pack2(c[10], c[11]));
        @(posedge clk);
    endtask

    // plausible camera: focal terms large, rotation-ish small terms, random translation
    task automatic load_random_camera;
        logic [31:0] c[12];
        foreach (c[k])
            c[k] = $urandom_range(8191) - 4096;
        c[0]  = $urandom_range(4096 * 1000, 4096 * 200);
        c[5]  = $urandom_range(4096 * 1000, 4096 * 200);
        c[10] = Q_ONE + $urandom_range(255);
        c[2]  = $urandom_range(4096 * 640);
        c[6]  = $urandom_range(4096 * 480);
        c[3]  = $urandom;
        c[7]  = $urandom;
        c[11] = $urandom_range(4096 * 64);
        load_camera(c);
    endtask

    task automatic send_random(int n);
        logic [CW-1:0] x, y, z;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                default:
                begin
                    x = $urandom_range(4096 * 4000) - 4096 * 2000;
                    y = $urandom_range(4096 * 4000) - 4096 * 2000;
                    z = $urandom_range(4096 * 500, 4096);
                end
            endcase
            send_point($urandom_range(1), x, y, z);
        end
    endtask

    task automatic test_reset_camera;
        send_point(MODE_PROJECT, 32'd4096, 32'd8192, 32'd4096);
        send_point(MODE_PROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'd4096);
        send_point(MODE_PROJECT, 32'h7fff_ffff, 32'h0, 32'd1);
        send_point(MODE_PROJECT, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        send_point(MODE_PROJECT, 32'd100, 32'd200, 32'd0);
        send_point(MODE_PROJECT, 32'hffff_ffff, 32'd1, 32'h8000_0000);
        send_point(MODE_BACKPROJECT, 32'd4096, 32'd4096, 32'hdead_beef);
        send_point(MODE_BACKPROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
        send_point(MODE_BACKPROJECT, 32'h0, 32'hffff_ffff, 32'h7fff_ffff);
        drain();
    endtask

    task automatic test_extreme_and_singular;
        logic [31:0] c[12];
        foreach (c[k])
            c[k] = k[0] ? 32'h8000_0000 : 32'h7fff_ffff;
        c[0] = 32'h7fff_ffff; c[5] = 32'h8000_0000; c[10] = 32'h7fff_ffff;
        c[1] = 32'h0; c[2] = 32'h1; c[4] = 32'h0;
        load_camera(c);
        send_point(MODE_PROJECT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(MODE_PROJECT, 32'h8000_0000, 32'h1, 32'h8000_0000);
        send_point(MODE_BACKPROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_point(MODE_BACKPROJECT, 32'h0, 32'h0, 32'h0);
        drain();
        // tiny matrix: small det blows up the inverse
        foreach (c[k])
            c[k] = 32'h0;
        c[0] = 32'h1; c[5] = 32'h1; c[10] = 32'h1; c[3] = 32'h7fff_ffff;
        load_camera(c);
        send_point(MODE_BACKPROJECT, 32'h7fff_ffff, 32'h1234_5678, 32'h0);
        send_point(MODE_PROJECT, 32'h1, 32'h1, 32'h1);
        drain();
        // rank-deficient: rows 0 and 1 equal
        foreach (c[k])
            c[k] = 32'h0;
        c[0] = Q_ONE; c[4] = Q_ONE; c[10] = Q_ONE; c[11] = Q_ONE;
        load_camera(c);
        send_point(MODE_BACKPROJECT, 32'd4096, 32'd4096, 32'd0);
        send_point(MODE_PROJECT, 32'd4096, 32'd4096, 32'hffff_f000);
        drain();
        write_reg(REG_BAD_6, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_BAD_7, 64'h0);
        @(posedge clk);
        send_point(MODE_BACKPROJECT, 32'd0, 32'd0, 32'd0);
        send_point(MODE_PROJECT, 32'd1, 32'd2, 32'd4096);
        drain();
    endtask

    task automatic test_random_cameras;
        int idle[3][2] = '{'{18, 81}, '{81, 18}, '{0, 0}};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = idle[p][0];
            recv_idle_pct = idle[p][1];
            load_random_camera();
            send_random(120);
            drain();
        end
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 10;
        load_random_camera();
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_random(80);
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point_ch.valid = 1'b0;
        point_ch.mode = MODE_PROJECT;
        point_ch.coord_x = '0;
        point_ch.coord_y = '0;
        point_ch.coord_z = '0;
        hold_off = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 81;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        sat_seen = 0;
        zero_seen = 0;
        cycle_count = 0;
        foreach (camera_regs[k])
            camera_regs[k] = pinhole_pkg::CFG_RESET[k];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_camera();
        test_extreme_and_singular();
        test_random_cameras();
        test_backpressure();

        $display("covered %0d items over reset, extreme, singular and random cameras",
                 items_sent);
        $display("results %0d, saturated %0d, zero w or singular %0d, errors %0d",
                 results_seen, sat_seen, zero_seen, error_count);
        if (error_count == 0)
            $display("pinhole_project_and_backproject_core regression: pass");
        else
            $display("pinhole_project_and_backproject_core regression: fail");
        $finish;
    end
endmodule
